/* hw/rtl/hpt_pkg.sv */
// ----------------------------------------------------------------------------
// hpt_pkg
// Shared types and constants for the homogeneous point transform core.
// ----------------------------------------------------------------------------
package hpt_pkg;

  localparam int COORD_W   = 32;
  localparam int WORD_W    = 64;
  localparam int NUM_REGS  = 8;
  localparam int REG_IDX_W = 3;
  localparam int ADDR_W    = 6;
  localparam int FRAC_BITS = 16;
  localparam int PROD_W    = 2 * COORD_W;
  localparam int TRANS_W   = COORD_W + FRAC_BITS;
  localparam int SUM_W     = PROD_W + 2;
  localparam int MAG_W     = SUM_W - 1;
  localparam int REM_W     = MAG_W + 1;
  localparam int QUO_W     = COORD_W;
  localparam int MAC_LAT   = 2;
  localparam int LANE_LAT  = QUO_W + 3;

  localparam logic [COORD_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [COORD_W-1:0] SAT_NEG = 32'h8000_0000;

  // identity matrix at reset
  localparam logic [WORD_W-1:0] REG_RESET [NUM_REGS] = '{
    64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
    64'h0, 64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000
  };

  // mat[row][col], each a signed Q16.16 coefficient
  typedef logic [3:0][3:0][COORD_W-1:0] mat_t;
  typedef logic [3:0][SUM_W-1:0] sums_t;

  typedef struct packed {
    logic                 wr_en;
    logic [REG_IDX_W-1:0] idx;
    logic [WORD_W-1:0]    data;
  } cfg_req_t;

endpackage

/* hw/rtl/hpt_regs.sv */
// ----------------------------------------------------------------------------
// hpt_regs
// Matrix coefficient register file behind the configuration port.
// ----------------------------------------------------------------------------
module hpt_regs import hpt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cfg_req_t          req,
  output logic [WORD_W-1:0] rdata,
  output mat_t              mat
);

  logic [WORD_W-1:0] regs [NUM_REGS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs[i] <= REG_RESET[i];
      end
    end else if (req.wr_en) begin
      regs[req.idx] <= req.data;
    end
  end

  assign rdata = regs[req.idx];

  // low word holds the even column, high word the odd one
  for (genvar r = 0; r < 4; r++) begin : g_row
    for (genvar c = 0; c < 4; c++) begin : g_col
      if (c % 2 == 0) begin : g_lo
        assign mat[r][c] = regs[r * 2 + c / 2][COORD_W-1:0];
      end else begin : g_hi
        assign mat[r][c] = regs[r * 2 + c / 2][WORD_W-1:COORD_W];
      end
    end
  end

endmodule

/* hw/rtl/hpt_mac.sv */
// ----------------------------------------------------------------------------
// hpt_mac
// Two-stage vector-matrix product: products, then exact column sums.
// ----------------------------------------------------------------------------
module hpt_mac import hpt_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [COORD_W-1:0] x,
  input  logic [COORD_W-1:0] y,
  input  logic [COORD_W-1:0] z,
  input  mat_t               mat,
  output logic               out_valid,
  output sums_t              sums
);

  logic signed [COORD_W-1:0] pt [3];
  logic signed [PROD_W-1:0]  prod [3][4];
  logic signed [TRANS_W-1:0] trans [4];
  logic                      v1;

  assign pt[0] = x;
  assign pt[1] = y;
  assign pt[2] = z;

  // stage 1: twelve 32x32 products plus translation row scaled by one
  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 4; c++) begin
        prod[r][c] <= pt[r] * $signed(mat[r][c]);
      end
    end
    for (int c = 0; c < 4; c++) begin
      trans[c] <= {mat[3][c], {FRAC_BITS{1'b0}}};
    end
  end

  // stage 2: exact column sums
  always_ff @(posedge clk) begin
    for (int c = 0; c < 4; c++) begin
      sums[c] <= SUM_W'(prod[0][c]) + SUM_W'(prod[1][c]) + SUM_W'(prod[2][c])
               + SUM_W'(trans[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

endmodule

/* hw/rtl/hpt_lane.sv */
// ----------------------------------------------------------------------------
// hpt_lane
// One component of the perspective divide: pipelined signed Q16.16 division
// with truncation toward zero and saturation, one quotient bit per stage.
// ----------------------------------------------------------------------------
module hpt_lane import hpt_pkg::*; (
  input  logic               clk,
  input  logic [SUM_W-1:0]   num,
  input  logic [SUM_W-1:0]   den,
  output logic [COORD_W-1:0] quo,
  output logic               sat
);

  logic [MAG_W-1:0] num_abs, den_abs;
  logic [MAG_W-1:0] nabs1, dabs1;
  logic             nneg1, dneg1;

  assign num_abs = num[SUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
  assign den_abs = den[SUM_W-1] ? MAG_W'(-den) : MAG_W'(den);

  // stage 1: magnitudes and signs
  always_ff @(posedge clk) begin
    nneg1 <= num[SUM_W-1];
    dneg1 <= den[SUM_W-1];
    nabs1 <= num_abs;
    dabs1 <= den_abs;
  end

  logic [REM_W-1:0] rem  [QUO_W+1];
  logic [QUO_W-1:0] nb   [QUO_W+1];
  logic [QUO_W-1:0] qq   [QUO_W+1];
  logic [MAG_W-1:0] dd   [QUO_W+1];
  logic             neg  [QUO_W+1];
  logic             ovf  [QUO_W+1];

  // stage 2: quotient of 2^32 or more is caught up front, so the
  // remaining partial remainder always stays below the divisor
  always_ff @(posedge clk) begin
    ovf[0] <= (MAG_W + FRAC_BITS)'(nabs1) >= {dabs1, {FRAC_BITS{1'b0}}};
    rem[0] <= REM_W'(nabs1 >> FRAC_BITS);
    nb[0]  <= {nabs1[FRAC_BITS-1:0], {(QUO_W-FRAC_BITS){1'b0}}};
    qq[0]  <= '0;
    dd[0]  <= dabs1;
    neg[0] <= nneg1 ^ dneg1;
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_step
    logic [REM_W-1:0] trial;
    logic             ge;

    assign trial = {rem[k][REM_W-2:0], nb[k][QUO_W-1]};
    assign ge    = trial >= {1'b0, dd[k]};

    always_ff @(posedge clk) begin
      rem[k+1] <= ge ? trial - {1'b0, dd[k]} : trial;
      qq[k+1]  <= {qq[k][QUO_W-2:0], ge};
      nb[k+1]  <= {nb[k][QUO_W-2:0], 1'b0};
      dd[k+1]  <= dd[k];
      neg[k+1] <= neg[k];
      ovf[k+1] <= ovf[k];
    end
  end

  // final stage: sign and clamp
  always_ff @(posedge clk) begin
    if (neg[QUO_W]) begin
      if (ovf[QUO_W] || qq[QUO_W] > SAT_NEG) begin
        quo <= SAT_NEG;
        sat <= 1'b1;
      end else begin
        quo <= -qq[QUO_W];
        sat <= 1'b0;
      end
    end else begin
      if (ovf[QUO_W] || qq[QUO_W][QUO_W-1]) begin
        quo <= SAT_POS;
        sat <= 1'b1;
      end else begin
        quo <= qq[QUO_W];
        sat <= 1'b0;
      end
    end
  end

endmodule

/* hw/rtl/homogeneous_point_transform_core.sv */
// ----------------------------------------------------------------------------
// homogeneous_point_transform_core
// 4x4 homogeneous transform of a Q16.16 point with perspective divide.
// ----------------------------------------------------------------------------
//
//  channel  | signals                                   | handshake
//  ---------+-------------------------------------------+----------------------
//  input    | in_x, in_y, in_z                          | start high, busy low
//  result   | out_x, out_y, out_z, w_was_zero, saturated| done, one cycle
//  config   | psel penable pwrite paddr pwdata prdata   | apb, pready tied high
//
//  one point per clock; busy never rises
//  from accepted start to done a point runs through hpt_mac, the 32 one-bit
//  division stages in each of the three divide lanes and the result register
//  rst is synchronous: clears valid flags and restores the identity matrix
//  the result side takes every transaction, so nothing stalls in the pipe
//
module homogeneous_point_transform_core import hpt_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [COORD_W-1:0] in_x,
  input  logic [COORD_W-1:0] in_y,
  input  logic [COORD_W-1:0] in_z,
  output logic               done,
  output logic [COORD_W-1:0] out_x,
  output logic [COORD_W-1:0] out_y,
  output logic [COORD_W-1:0] out_z,
  output logic               w_was_zero,
  output logic               saturated,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [WORD_W-1:0]  pwdata,
  output logic [WORD_W-1:0]  prdata,
  output logic               pready
);

  localparam int TOTAL_LAT = MAC_LAT + LANE_LAT + 1;

  // pipe never blocks
  assign busy   = 1'b0;
  assign pready = 1'b1;

  logic accept;
  assign accept = start & ~busy;

  // configuration port, registers at 8-byte spacing
  cfg_req_t req;
  mat_t     mat;

  assign req.wr_en = psel & penable & pwrite & pready;
  assign req.idx   = paddr[ADDR_W-1:ADDR_W-REG_IDX_W];
  assign req.data  = pwdata;

  hpt_regs u_regs (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .rdata (prdata),
    .mat   (mat)
  );

  // products and column sums; column 3 is w
  logic  mac_valid;
  sums_t sums;

  hpt_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .x         (in_x),
    .y         (in_y),
    .z         (in_z),
    .mat       (mat),
    .out_valid (mac_valid),
    .sums      (sums)
  );

  // three divide lanes share the w column as divisor
  logic [COORD_W-1:0] quo [3];
  logic [2:0]         lane_sat;

  for (genvar c = 0; c < 3; c++) begin : g_lane
    hpt_lane u_lane (
      .clk (clk),
      .num (sums[c]),
      .den (sums[3]),
      .quo (quo[c]),
      .sat (lane_sat[c])
    );
  end

  // valid and zero-w flag ride alongside the lanes
  logic vd [LANE_LAT];
  logic wz [LANE_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LANE_LAT; i++) begin
        vd[i] <= 1'b0;
      end
    end else begin
      vd[0] <= mac_valid;
      for (int i = 1; i < LANE_LAT; i++) begin
        vd[i] <= vd[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    wz[0] <= (sums[3] == '0);
    for (int i = 1; i < LANE_LAT; i++) begin
      wz[i] <= wz[i-1];
    end
  end

  // result register: a zero w forces the zero vector
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vd[LANE_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    w_was_zero <= wz[LANE_LAT-1];
    if (wz[LANE_LAT-1]) begin
      out_x     <= '0;
      out_y     <= '0;
      out_z     <= '0;
      saturated <= 1'b0;
    end else begin
      out_x     <= quo[0];
      out_y     <= quo[1];
      out_z     <= quo[2];
      saturated <= |lane_sat;
    end
  end

  // every accepted transaction comes out after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##TOTAL_LAT done)
    else $error("result strobe missing after fixed latency");

  // zero w gives the zero vector without saturation
  a_zero_w: assert property (@(posedge clk) disable iff (rst)
    done && w_was_zero |-> out_x == '0 && out_y == '0 && out_z == '0 && !saturated)
    else $error("zero w result not cleared");

  // a raised saturation flag comes with at least one component at a limit value
  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    done && saturated |-> out_x == SAT_POS || out_x == SAT_NEG || out_y == SAT_POS
      || out_y == SAT_NEG || out_z == SAT_POS || out_z == SAT_NEG)
    else $error("saturation flag without a clamped component");

endmodule
